[rtl/dlsq_pkg.sv]
// Package for the delta-list sleep queue: queue sizing, entry layout,
// request/result codes and the ring index helper.
// No dependencies.
package dlsq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int WAKE_LIMIT  = 16;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [7:0]       tid_t;
	typedef logic [31:0]      ticks_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		ticks_t delta;
		tid_t   thread;
	} entry_t;

	localparam logic REQ_TICK    = 1'b0;
	localparam logic REQ_INSERT  = 1'b1;
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_WAKE   = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Ring position of a list place counted from the head.
	// head < depth and place <= depth, so one conditional subtract is enough.
	function automatic idx_t ring_idx(input idx_t head, input cnt_t place);
		logic [CNT_W+1:0] s;
		begin
			s = (CNT_W+2)'(head) + (CNT_W+2)'(place);
			if (s >= (CNT_W+2)'(QUEUE_DEPTH)) begin
				s = s - (CNT_W+2)'(QUEUE_DEPTH);
			end
			return s[IDX_W-1:0];
		end
	endfunction

endpackage

[rtl/delta_list_sleep_queue.sv]
// Delta-list sleep queue, top level: sequencer, ring memory and output register.
// Depends on dlsq_pkg.
//
// Sleeping threads are held in a ring of QUEUE_DEPTH entries, each holding a
// thread id and its wait in ticks after the entry before it. An insert item
// (req_type = 1) walks the list from the head one entry per cycle, adding up
// deltas, and places the thread before the first entry whose running sum is
// above its wait (ties go behind); that entry keeps its own wake time because
// its delta is split. A zero wait counts as one tick. Every insert returns one
// acknowledgement item, with insert_status set when the queue was full and the
// thread was dropped. A tick item (req_type = 0) takes one off the head delta
// (holding at zero) and then hands out every leading thread whose delta is
// zero, up to WAKE_LIMIT per tick, as woken items; last_of_run marks the final
// one. A tick on an empty queue, or one that wakes nobody, returns nothing.
// One item is worked on at a time and in_stall stays high until its work is
// done. Timing is set by the single read port of the entry memory, one entry
// per cycle: an insert walks the list up to its place, shifts the tail, writes
// the new entry, gives the acknowledgement and goes back to idle, so its time
// does not depend on the place; an insert into a full queue goes straight to
// the acknowledgement. A tick decrements the head delta and then hands out the
// woken threads; the work waits while out_stall holds a result back.
module delta_list_sleep_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  dlsq_pkg::tid_t      thread_id,
	input  dlsq_pkg::ticks_t    sleep_ticks,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output dlsq_pkg::tid_t      woken_id,
	output logic                insert_status,
	output logic                last_of_run
);
	import dlsq_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1; // insert: find place
	localparam logic [2:0] ST_SHIFT = 3'd2; // insert: move tail up one
	localparam logic [2:0] ST_FIN   = 3'd3; // insert: write new entry
	localparam logic [2:0] ST_ACK   = 3'd4; // insert: give acknowledgement
	localparam logic [2:0] ST_TDEC  = 3'd5; // tick: decrement head delta
	localparam logic [2:0] ST_TWAKE = 3'd6; // tick: hand out woken threads

	logic [2:0] state_q;
	idx_t       head_q;
	cnt_t       count_q;

	// entry memory, one write and one registered read per cycle
	entry_t mem_q [QUEUE_DEPTH];
	entry_t rdata_q;
	idx_t   raddr;
	logic   wr_en;
	idx_t   waddr;
	entry_t wdata;

	// insert working registers
	ticks_t ticks_q;
	tid_t   tid_q;
	ticks_t sum_q;
	cnt_t   idx_q;
	cnt_t   pos_q;
	cnt_t   sh_q;
	ticks_t newdelta_q;
	ticks_t split_q;
	logic   st_q;

	// tick working registers
	cnt_t woken_q;
	tid_t cur_tid_q;

	// output register
	logic out_valid_q;
	logic kind_q;
	tid_t id_q;
	logic status_q;
	logic last_q;

	logic        in_acc;
	logic        out_free;
	logic        out_load;
	logic [32:0] nsum;
	logic        at_end;
	logic        found;
	ticks_t      dnew;
	logic        next_wakes;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	// a result goes into the output register this cycle
	assign out_load = out_free && ((state_q == ST_ACK) || (state_q == ST_TWAKE));

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign woken_id      = id_q;
	assign insert_status = status_q;
	assign last_of_run   = last_q;

	// walk: running sum, place found when the wait falls short of it
	assign nsum   = {1'b0, sum_q} + {1'b0, rdata_q.delta};
	assign at_end = (idx_q == count_q);
	assign found  = !at_end && ({1'b0, ticks_q} < nsum);

	assign dnew = (rdata_q.delta == '0) ? '0 : rdata_q.delta - 32'd1;

	// rdata_q holds the entry just behind the current woken one
	assign next_wakes = (woken_q < count_q) && (int'(woken_q) < WAKE_LIMIT)
		&& (rdata_q.delta == '0);

	// read address and write port
	always_comb begin
		raddr = head_q;
		wr_en = 1'b0;
		waddr = head_q;
		wdata = rdata_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = head_q;
			end
			ST_WALK: begin
				raddr = found ? ring_idx(head_q, count_q - cnt_t'(1))
					: ring_idx(head_q, idx_q + cnt_t'(1));
			end
			ST_SHIFT: begin
				if (sh_q != pos_q) begin
					raddr = ring_idx(head_q, sh_q - cnt_t'(1));
				end
				wr_en = 1'b1;
				waddr = ring_idx(head_q, sh_q + cnt_t'(1));
				wdata = (sh_q == pos_q) ? entry_t'{delta: split_q, thread: rdata_q.thread}
					: rdata_q;
			end
			ST_FIN: begin
				wr_en = 1'b1;
				waddr = ring_idx(head_q, pos_q);
				wdata = '{delta: newdelta_q, thread: tid_q};
			end
			ST_ACK: begin
				raddr = head_q;
			end
			ST_TDEC: begin
				raddr = ring_idx(head_q, cnt_t'(1));
				wr_en = 1'b1;
				waddr = head_q;
				wdata = '{delta: dnew, thread: rdata_q.thread};
			end
			ST_TWAKE: begin
				raddr = (out_free && next_wakes) ? ring_idx(head_q, woken_q + cnt_t'(1))
					: ring_idx(head_q, woken_q);
			end
			default: begin
				raddr = head_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type == REQ_INSERT) begin
							state_q <= (int'(count_q) >= QUEUE_DEPTH) ? ST_ACK : ST_WALK;
						end else if (count_q != '0) begin
							state_q <= ST_TDEC;
						end
					end
				end
				ST_WALK: begin
					if (at_end) begin
						state_q <= ST_FIN;
					end else if (found) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (sh_q == pos_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					count_q <= count_q + cnt_t'(1);
					state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TDEC: begin
					state_q <= (dnew == '0) ? ST_TWAKE : ST_IDLE;
				end
				ST_TWAKE: begin
					if (out_free) begin
						if (!next_wakes) begin
							head_q  <= ring_idx(head_q, woken_q);
							count_q <= count_q - woken_q;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ticks_q <= (sleep_ticks == '0) ? 32'd1 : sleep_ticks;
				tid_q   <= thread_id;
				sum_q   <= '0;
				idx_q   <= '0;
				st_q    <= (int'(count_q) >= QUEUE_DEPTH) ? STATUS_FULL : STATUS_OK;
			end
			ST_WALK: begin
				if (at_end) begin
					newdelta_q <= ticks_q - sum_q;
					pos_q      <= count_q;
				end else if (found) begin
					newdelta_q <= ticks_q - sum_q;
					split_q    <= nsum[31:0] - ticks_q;
					pos_q      <= idx_q;
					sh_q       <= count_q - cnt_t'(1);
				end else begin
					sum_q <= nsum[31:0];
					idx_q <= idx_q + cnt_t'(1);
				end
			end
			ST_SHIFT: begin
				sh_q <= sh_q - cnt_t'(1);
			end
			ST_ACK: begin
				if (out_free) begin
					kind_q   <= KIND_ACK;
					id_q     <= '0;
					status_q <= st_q;
					last_q   <= 1'b1;
				end
			end
			ST_TDEC: begin
				cur_tid_q <= rdata_q.thread;
				woken_q   <= cnt_t'(1);
			end
			ST_TWAKE: begin
				if (out_free) begin
					kind_q   <= KIND_WAKE;
					id_q     <= cur_tid_q;
					status_q <= STATUS_OK;
					last_q   <= !next_wakes;
					if (next_wakes) begin
						cur_tid_q <= rdata_q.thread;
						woken_q   <= woken_q + cnt_t'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= QUEUE_DEPTH)
		else $error("entry count above queue depth");

	a_walk_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (sum_q <= ticks_q))
		else $error("running sum passed the wait during walk");

	a_woken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TWAKE) |-> (woken_q <= count_q && woken_q != '0))
		else $error("woken count out of range");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_ACK || $past(state_q) == ST_TWAKE))
		else $error("result raised outside acknowledge or wake");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req_type == REQ_INSERT && int'(count_q) >= QUEUE_DEPTH)
		|=> (count_q == $past(count_q)))
		else $error("full queue took an insert");

endmodule
